// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Operation codes, error codes, sequencer states and the default width.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DEF_WIDTH = 32;

  // operation codes
  localparam logic [2:0] KIND_NORM = 3'd0;
  localparam logic [2:0] KIND_ADD  = 3'd1;
  localparam logic [2:0] KIND_SUB  = 3'd2;
  localparam logic [2:0] KIND_MUL  = 3'd3;
  localparam logic [2:0] KIND_DIV  = 3'd4;
  localparam logic [2:0] KIND_LT   = 3'd5;
  localparam logic [2:0] KIND_EQ   = 3'd6;
  localparam logic [2:0] KIND_NONE = 3'd7;

  // error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CMP,
    ST_TWOS,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_CHECK
  } state_t;

endpackage

// File: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact fraction arithmetic with lowest-terms result
// Normalizes, adds, subtracts, multiplies, divides or compares two fractions.
// ----------------------------------------------------------------------------
// Usage
//   Input beat: drive kind and the four operand fields and raise start while
//   busy is low; the beat is taken at that clock edge. Only the low WIDTH
//   bits of each operand are used, sign-extended from bit WIDTH-1.
//   Result beat: done pulses high for one cycle with res_num, res_den,
//   compare_true and error valid. The receiver cannot stall; it must take
//   the beat in that cycle.
//   Flow: early outcomes (unused kind, zero denominator, division by zero)
//   come back in the cycle after start. Otherwise one multiplier step per
//   product (up to three), then a common-factor-of-two strip and a binary
//   gcd (one subtract or shift a cycle; each step drops at least one bit of
//   the two 2*WIDTH-bit values) and two restoring divisions through one
//   shared divider. The gcd loop and the divider set the worst case.
//   Compares finish after the two cross products.
//   One item at a time: busy stays high until the result beat.
//   Reset (rst, synchronous) returns the sequencer to idle with no pending
//   result beat.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic               done,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               compare_true,
  output logic [1:0]         error
);

  localparam int P  = 2 * WIDTH;          // product / working width
  localparam int CW = $clog2(P);
  localparam logic [P-1:0] HALF = {{(P-1){1'b0}}, 1'b1} << (WIDTH - 1);
  localparam logic [P-1:0] ONE  = {{(P-1){1'b0}}, 1'b1};

  function automatic logic [WIDTH-1:0] mag_of(input logic [31:0] v);
    logic [WIDTH-1:0] f;
    f = v[WIDTH-1:0];
    return f[WIDTH-1] ? (~f + 1'b1) : f;
  endfunction

  state_t state, state_next;

  logic [2:0]       kind_r, kind_r_next;
  logic [WIDTH-1:0] an, an_next, ad, ad_next, bn, bn_next, bd, bd_next;
  logic             sa, sa_next, sb, sb_next, rneg, rneg_next;
  logic [P-1:0]     x, x_next, y, y_next, gx, gx_next, gy, gy_next;
  logic [P-1:0]     dq, dq_next, rem, rem_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic             done_next, cmp_next;
  logic signed [31:0] res_num_next;
  logic [30:0]      res_den_next;
  logic [1:0]       error_next;

  // shared multiplier
  logic [WIDTH-1:0] mul_a, mul_b;
  logic [P-1:0]     prod;
  assign prod = mul_a * mul_b;

  // shared divider step (restoring, one quotient bit a cycle)
  logic [P:0]   r2, rsub;
  logic         ge;
  logic [P-1:0] qbits;
  assign r2    = {rem, dq[P-1]};
  assign rsub  = r2 - {1'b0, gy};
  assign ge    = r2 >= {1'b0, gy};
  assign qbits = {dq[P-2:0], ge};

  // operand magnitudes straight from the ports
  logic [WIDTH-1:0] an_in, ad_in, bn_in, bd_in;
  assign an_in = mag_of(a_num);
  assign ad_in = mag_of(a_den);
  assign bn_in = mag_of(b_num);
  assign bd_in = mag_of(b_den);

  logic s1, s2, sub_flip;
  logic [31:0] n32;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    kind_r       <= kind_r_next;
    an           <= an_next;
    ad           <= ad_next;
    bn           <= bn_next;
    bd           <= bd_next;
    sa           <= sa_next;
    sb           <= sb_next;
    rneg         <= rneg_next;
    x            <= x_next;
    y            <= y_next;
    gx           <= gx_next;
    gy           <= gy_next;
    dq           <= dq_next;
    rem          <= rem_next;
    cnt          <= cnt_next;
    res_num      <= res_num_next;
    res_den      <= res_den_next;
    compare_true <= cmp_next;
    error        <= error_next;
  end

  always_comb begin
    state_next   = state;
    kind_r_next  = kind_r;
    an_next      = an;
    ad_next      = ad;
    bn_next      = bn;
    bd_next      = bd;
    sa_next      = sa;
    sb_next      = sb;
    rneg_next    = rneg;
    x_next       = x;
    y_next       = y;
    gx_next      = gx;
    gy_next      = gy;
    dq_next      = dq;
    rem_next     = rem;
    cnt_next     = cnt;
    done_next    = 1'b0;
    res_num_next = res_num;
    res_den_next = res_den;
    cmp_next     = compare_true;
    error_next   = error;
    mul_a        = an;
    mul_b        = bd;
    sub_flip     = (kind_r == KIND_SUB);
    s1           = sa && (x != '0);
    s2           = (sb ^ sub_flip) && (y != '0);
    n32          = 32'(x[WIDTH-1:0]);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          kind_r_next  = kind;
          an_next      = an_in;
          ad_next      = ad_in;
          bn_next      = bn_in;
          bd_next      = bd_in;
          sa_next      = a_num[WIDTH-1] ^ a_den[WIDTH-1];
          sb_next      = b_num[WIDTH-1] ^ b_den[WIDTH-1];
          // default answer 0/1, used by every early exit
          res_num_next = '0;
          res_den_next = 31'd1;
          cmp_next     = 1'b0;
          error_next   = ERR_OK;
          if (kind == KIND_NONE) begin
            done_next = 1'b1;
          end else if (ad_in == '0 || (kind != KIND_NORM && bd_in == '0)) begin
            error_next = ERR_ZERO_DEN;
            done_next  = 1'b1;
          end else if (kind == KIND_DIV && bn_in == '0) begin
            error_next = ERR_DIV_ZERO;
            done_next  = 1'b1;
          end else if (kind == KIND_NORM) begin
            x_next     = P'(an_in);
            y_next     = P'(ad_in);
            rneg_next  = a_num[WIDTH-1] ^ a_den[WIDTH-1];
            state_next = ST_TWOS;
          end else begin
            state_next = ST_MUL1;
          end
        end
      end

      ST_MUL1: begin
        mul_a      = an;
        mul_b      = (kind_r == KIND_MUL) ? bn : bd;
        x_next     = prod;
        rneg_next  = sa ^ sb;
        state_next = ST_MUL2;
      end

      ST_MUL2: begin
        case (kind_r)
          KIND_MUL: begin
            mul_a = ad;
            mul_b = bd;
          end
          KIND_DIV: begin
            mul_a = ad;
            mul_b = bn;
          end
          default: begin
            mul_a = bn;
            mul_b = ad;
          end
        endcase
        y_next = prod;
        case (kind_r) inside
          KIND_ADD, KIND_SUB: state_next = ST_MUL3;
          KIND_LT, KIND_EQ:   state_next = ST_CMP;
          default:            state_next = ST_TWOS;
        endcase
      end

      ST_MUL3: begin
        // signed-magnitude add of the cross products; denominator product
        mul_a  = ad;
        mul_b  = bd;
        y_next = prod;
        if (s1 == s2) begin
          x_next    = x + y;
          rneg_next = s1;
        end else if (x >= y) begin
          x_next    = x - y;
          rneg_next = s1;
        end else begin
          x_next    = y - x;
          rneg_next = s2;
        end
        state_next = ST_TWOS;
      end

      ST_CMP: begin
        if (kind_r == KIND_LT) begin
          cmp_next = (s1 != s2) ? s1 : (s1 ? (x > y) : (x < y));
        end else begin
          cmp_next = (s1 == s2) && (x == y);
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_TWOS: begin
        // zero -> 0/1; else strip common factors of two
        if (x == '0) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (x[0] || y[0]) begin
          gx_next    = x;
          gy_next    = y;
          state_next = ST_GCD;
        end else begin
          x_next = x >> 1;
          y_next = y >> 1;
        end
      end

      ST_GCD: begin
        // binary gcd, at least one side odd; result ends in gy
        if (gx == '0 || gy == '0) begin
          if (gy == '0) gy_next = gx;
          dq_next    = x;
          rem_next   = '0;
          cnt_next   = '0;
          state_next = ST_DIVN;
        end else if (!gx[0]) begin
          gx_next = gx >> 1;
        end else if (!gy[0]) begin
          gy_next = gy >> 1;
        end else if (gx >= gy) begin
          gx_next = (gx - gy) >> 1;
        end else begin
          gy_next = (gy - gx) >> 1;
        end
      end

      ST_DIVN: begin
        rem_next = ge ? rsub[P-1:0] : r2[P-1:0];
        dq_next  = qbits;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(P - 1)) begin
          x_next     = qbits;
          dq_next    = y;
          rem_next   = '0;
          cnt_next   = '0;
          state_next = ST_DIVD;
        end
      end

      ST_DIVD: begin
        rem_next = ge ? rsub[P-1:0] : r2[P-1:0];
        dq_next  = qbits;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(P - 1)) begin
          y_next     = qbits;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (y > HALF - ONE || x > (rneg ? HALF : HALF - ONE)) begin
          error_next = ERR_OVERFLOW;
        end else begin
          res_num_next = rneg ? -n32 : n32;
          res_den_next = 31'(y[WIDTH-1:0]);
        end
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result beat while busy");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    done && error != ERR_OK |-> res_num == 0 && res_den == 31'd1 && !compare_true)
    else $error("error beat carries a value");

  a_zero_one : assert property (@(posedge clk) disable iff (rst)
    done && res_num == 0 |-> res_den == 31'd1) else $error("zero not 0/1");

  a_cmp_ok : assert property (@(posedge clk) disable iff (rst)
    done && compare_true |-> error == ERR_OK) else $error("compare with error");

  a_start : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("accepted beat dropped");

endmodule

// File: test/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// A directed table covers extremes, every operation and the error cases, then
// random beats with skewed operands; each result is checked against an exact
// lowest-terms fraction model computed inside the bench.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int  W          = DEF_WIDTH;
  localparam int  N_RANDOM   = 1630;
  localparam int  DRAIN_CYC  = 10 * W + 20;
  localparam int  N_TABLE    = 24;

  // one expected result beat
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    logic [1:0]         err;
  } frac_result_t;

  // one stimulus row; chk marks rows whose answer is typed in
  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] an, ad, bn, bd;
    logic               chk;
    frac_result_t       res;
  } stim_row_t;

  logic               clk, rst, start, busy, done;
  logic [2:0]         kind;
  logic signed [31:0] a_num, a_den, b_num, b_den;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               compare_true;
  logic [1:0]         error;

  frac_result_t expected_q[$];
  int           mismatches;
  int           results_seen;
  int           kind_count[8];

  rational_arithmetic_unit #(.WIDTH(W)) dut (
    .clk, .rst, .start, .busy, .kind, .a_num, .a_den, .b_num, .b_den,
    .done, .res_num, .res_den, .compare_true, .error
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(2000 * 400 * 10 * 3);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // exact fraction model: sign plus 64-bit magnitudes
  // --------------------------------------------------------------------------
  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // magnitude of a W-bit sign-extended field
  function automatic logic [63:0] field_mag(logic [31:0] v, output logic neg);
    logic [63:0] full, x;
    full = 64'd1 << W;
    x    = {32'd0, v} & (full - 1);
    neg  = x[W-1];
    return neg ? full - x : x;
  endfunction

  // reduce n/d; zero becomes +0/1
  function automatic void reduce(input logic neg, input logic [63:0] n,
                                 input logic [63:0] d, output logic rneg,
                                 output logic [63:0] rn, output logic [63:0] rd);
    logic [63:0] g;
    if (n == 0) begin
      rneg = 1'b0; rn = 0; rd = 1;
    end else begin
      g = gcd64(n, d);
      rneg = neg; rn = n / g; rd = d / g;
    end
  endfunction

  function automatic logic same_result(frac_result_t x, frac_result_t y);
    return (x.num === y.num) && (x.den === y.den) && (x.cmp === y.cmp) &&
           (x.err === y.err);
  endfunction

  function automatic frac_result_t predict_fraction(logic [2:0] k, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    frac_result_t r;
    logic        nn, dn, aneg, bneg, s1, s2, rneg, have;
    logic [63:0] anm, adm, bnm, bdm, am, ada, bm, bda, t1, t2, rn, rd, full, half;
    full = 64'd1 << W;
    half = 64'd1 << (W - 1);
    r    = '{num: 0, den: 1, cmp: 0, err: ERR_OK};
    have = 1'b0;
    rneg = 1'b0; rn = 0; rd = 1;
    if (k == KIND_NONE) return r;
    if ((({32'd0, ad} & (full - 1)) == 0) ||
        (k != KIND_NORM && (({32'd0, bd} & (full - 1)) == 0))) begin
      r.err = ERR_ZERO_DEN;
      return r;
    end
    anm = field_mag(an, nn); adm = field_mag(ad, dn);
    reduce(nn != dn, anm, adm, aneg, am, ada);
    bnm = field_mag(bn, nn); bdm = field_mag(bd, dn);
    reduce(nn != dn, bnm, bdm, bneg, bm, bda);
    t1 = am * bda;
    t2 = bm * ada;
    s1 = aneg && t1 != 0;
    s2 = bneg && t2 != 0;
    case (k) inside
      KIND_NORM: begin
        rneg = aneg; rn = am; rd = ada; have = 1'b1;
      end
      KIND_ADD, KIND_SUB: begin
        if (k == KIND_SUB && t2 != 0) s2 = ~s2;
        if (s1 == s2)     reduce(s1, t1 + t2, ada * bda, rneg, rn, rd);
        else if (t1 >= t2) reduce(s1, t1 - t2, ada * bda, rneg, rn, rd);
        else              reduce(s2, t2 - t1, ada * bda, rneg, rn, rd);
        have = 1'b1;
      end
      KIND_MUL: begin
        reduce(aneg != bneg, am * bm, ada * bda, rneg, rn, rd);
        have = 1'b1;
      end
      KIND_DIV: begin
        if (bm == 0) r.err = ERR_DIV_ZERO;
        else begin
          reduce(aneg != bneg, t1, ada * bm, rneg, rn, rd);
          have = 1'b1;
        end
      end
      KIND_LT: r.cmp = (s1 != s2) ? s1 : (s1 ? t1 > t2 : t1 < t2);
      default: r.cmp = (s1 == s2) && (t1 == t2);
    endcase
    if (have) begin
      if (rd > half - 1 || rn > (rneg ? half : half - 1)) r.err = ERR_OVERFLOW;
      else begin
        r.num = rneg ? 32'(64'd0 - rn) : 32'(rn);
        r.den = 31'(rd);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // result side: the receiver never stalls, so every done is one beat
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    frac_result_t e;
    if (!rst && done) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t result beat with nothing expected", $realtime);
      end else begin
        e = expected_q.pop_front();
        if (res_num !== e.num)      report_mismatch("res_num", res_num, e.num);
        if (res_den !== e.den)      report_mismatch("res_den", res_den, e.den);
        if (compare_true !== e.cmp) report_mismatch("compare_true", compare_true, e.cmp);
        if (error !== e.err)        report_mismatch("error", error, e.err);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  // one beat: wait for a free edge, hold start through it, predict on accept;
  // start stays high afterwards until the next beat or an idle cycle drops it
  task automatic send_beat(input logic [2:0] k, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd, input logic idle_ok,
                           input logic chk, input frac_result_t typed);
    frac_result_t p;
    while (idle_ok && $urandom_range(99) < 12) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind  <= k;
    a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_fraction(k, an, ad, bn, bd);
    if (chk && !same_result(p, typed)) begin
      mismatches++;
      $display("%0t table row answer disagrees with model, kind %0d", $realtime, k);
    end
    expected_q.push_back(p);
    kind_count[k]++;
  endtask

  // operand values skewed toward edges and small numbers
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom_range(2)) - 32'd1;
      3, 4:    return 32'($urandom_range(40)) - 32'd20;
      5:       return 32'($urandom_range(2000)) - 32'd1000;
      6:       return 32'($urandom_range(16'hFFFF)) << $urandom_range(16);
      default: return $urandom();
    endcase
  endfunction

  stim_row_t directed_rows[N_TABLE];

  initial begin
    stim_row_t   row;
    frac_result_t none;
    logic [2:0]  k;
    logic [31:0] ad, bd;
    none = '{num: 0, den: 1, cmp: 0, err: ERR_OK};
    directed_rows = '{
      '{KIND_NORM, 6, -4, 0, 1, 1, '{-3, 2, 0, ERR_OK}},
      '{KIND_NORM, 0, -7, 0, 0, 1, '{0, 1, 0, ERR_OK}},
      '{KIND_NORM, 5, 0, 0, 0, 1, '{0, 1, 0, ERR_ZERO_DEN}},
      '{KIND_NORM, 32'h8000_0000, 1, 0, 0, 1, '{32'h8000_0000, 1, 0, ERR_OK}},
      '{KIND_NORM, 32'h8000_0000, -1, 0, 0, 1, '{0, 1, 0, ERR_OVERFLOW}},
      '{KIND_NORM, 1, 32'h8000_0000, 0, 0, 1, '{0, 1, 0, ERR_OVERFLOW}},
      '{KIND_NORM, -2, 32'h8000_0000, 0, 0, 1, '{1, 31'h4000_0000, 0, ERR_OK}},
      '{KIND_ADD, 1, 2, 1, 3, 1, '{5, 6, 0, ERR_OK}},
      '{KIND_ADD, 1, 2, 0, 0, 1, '{0, 1, 0, ERR_ZERO_DEN}},
      '{KIND_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1, '{0, 1, 0, ERR_OVERFLOW}},
      '{KIND_SUB, 1, 2, 1, 2, 1, '{0, 1, 0, ERR_OK}},
      '{KIND_SUB, 1, 3, 1, 2, 1, '{-1, 6, 0, ERR_OK}},
      '{KIND_MUL, -2, 3, 3, -4, 1, '{1, 2, 0, ERR_OK}},
      '{KIND_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1, '{0, 1, 0, ERR_OVERFLOW}},
      '{KIND_DIV, 1, 2, 0, 5, 1, '{0, 1, 0, ERR_DIV_ZERO}},
      '{KIND_DIV, 3, 4, -3, 8, 1, '{-2, 1, 0, ERR_OK}},
      '{KIND_DIV, 0, 0, 0, 5, 1, '{0, 1, 0, ERR_ZERO_DEN}},
      '{KIND_LT, -1, 2, 1, 3, 1, '{0, 1, 1, ERR_OK}},
      '{KIND_LT, 1, 2, 2, 4, 1, '{0, 1, 0, ERR_OK}},
      '{KIND_EQ, 1, 2, -2, -4, 1, '{0, 1, 1, ERR_OK}},
      '{KIND_EQ, 0, 3, 0, -9, 1, '{0, 1, 1, ERR_OK}},
      '{KIND_NONE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 1, '{0, 1, 0, ERR_OK}},
      '{KIND_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, none},
      '{KIND_SUB, 32'h8000_0000, 3, 32'h7FFF_FFFF, -7, 0, none}
    };
    mismatches = 0;
    results_seen = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    kind  <= KIND_NORM;
    a_num <= 0; a_den <= 1; b_num <= 0; b_den <= 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_beat(row.kind, row.an, row.ad, row.bn, row.bd, 1'b0, row.chk, row.res);
    end

    // random beats; the first stretch runs back to back
    for (int n = 0; n < N_RANDOM; n++) begin
      k  = ($urandom_range(29) == 0) ? KIND_NONE : 3'($urandom_range(6));
      ad = rand_operand();
      bd = rand_operand();
      if ($urandom_range(40) == 0) ad = 0;
      if ($urandom_range(40) == 0) bd = 0;
      send_beat(k, rand_operand(), ad, rand_operand(), bd, n >= 300, 1'b0, none);
    end
    start <= 1'b0;

    // drain: wait out the queue, then the worst-case latency
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d beats: norm %0d add %0d sub %0d mul %0d div %0d lt %0d eq %0d",
             results_seen, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5], kind_count[6]);
    $display("unused-kind %0d beats, %0d mismatches", kind_count[7], mismatches);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
